FILE: rtl/mbr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mailbox rings package
// Request codes, default sizes and the command bundle that the controller
// sends to the datapath.
// ----------------------------------------------------------------------------
package mbr_pkg;

	// Default sizes of the ring bank.
	localparam int CoreCountDef = 8;
	localparam int RingDepthDef = 16;

	// Field widths fixed by the request and result formats.
	localparam int ModeW = 3;
	localparam int CoreW = 8;
	localparam int MsgW  = 64;

	// Request codes.
	localparam logic [ModeW-1:0] MODE_CLEAR = 3'd0;
	localparam logic [ModeW-1:0] MODE_BIND  = 3'd1;
	localparam logic [ModeW-1:0] MODE_READY = 3'd2;
	localparam logic [ModeW-1:0] MODE_QUERY = 3'd3;
	localparam logic [ModeW-1:0] MODE_SEND  = 3'd4;
	localparam logic [ModeW-1:0] MODE_RECV  = 3'd5;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;  // capture the incoming request word
		logic exec;  // carry out the captured request
	} cmd_t;

endpackage

FILE: rtl/mbr_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mailbox rings controller
// Sequences each request through capture, execution and result delivery,
// and drives both channel handshakes.
// ----------------------------------------------------------------------------
module mbr_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	output logic          out_valid,
	input  logic          out_stall,
	output mbr_pkg::cmd_t cmd
);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_EXEC = 3'b010,
		S_OUT  = 3'b100
	} state_t;

	state_t state_q;
	state_t state_d;

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				state_d = S_OUT;
			end
			S_OUT: begin
				if (!out_stall) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Handshakes and datapath commands.
	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign cmd.load  = (state_q == S_IDLE) && in_valid;
	assign cmd.exec  = (state_q == S_EXEC);

endmodule

FILE: rtl/mbr_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mailbox rings datapath
// Holds the bound flags, the pointer pairs and the message memory, and
// computes the result word of each request.
// ----------------------------------------------------------------------------
module mbr_datapath #(
	parameter int CORE_COUNT = mbr_pkg::CoreCountDef,
	parameter int RING_DEPTH = mbr_pkg::RingDepthDef
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  mbr_pkg::cmd_t             cmd,
	input  logic [mbr_pkg::ModeW-1:0] mode,
	input  logic [mbr_pkg::CoreW-1:0] core,
	input  logic [mbr_pkg::MsgW-1:0]  message,
	output logic                      status,
	output logic                      ready_res,
	output logic [mbr_pkg::MsgW-1:0]  message_out
);

	localparam int CW       = (CORE_COUNT > 1) ? $clog2(CORE_COUNT) : 1;
	localparam int PW       = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam int AW       = CW + PW;
	localparam int MemDepth = CORE_COUNT * (1 << PW);

	// Captured request.
	logic [mbr_pkg::ModeW-1:0] mode_q;
	logic [mbr_pkg::CoreW-1:0] core_q;
	logic [mbr_pkg::MsgW-1:0]  msg_q;

	// Ring state.
	logic [CORE_COUNT-1:0] flag_q;
	logic [PW-1:0]         wptr_q [CORE_COUNT];
	logic [PW-1:0]         rptr_q [CORE_COUNT];
	logic [mbr_pkg::MsgW-1:0] mem [MemDepth];

	// Result registers.
	logic                     status_q;
	logic                     ready_q;
	logic                     recv_ok_q;
	logic [mbr_pkg::MsgW-1:0] rdata_q;

	// Decode of the captured request.
	logic          in_range;
	logic [CW-1:0] idx;
	logic [PW-1:0] wp;
	logic [PW-1:0] rp;
	logic [PW-1:0] wp_next;
	logic [PW-1:0] rp_next;
	logic          flag;
	logic          do_clear;
	logic          do_flag;
	logic          do_send;
	logic          do_recv;
	logic          res_status;
	logic          res_ready;

	// Capture the request word when it is accepted.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= mode;
			core_q <= core;
			msg_q  <= message;
		end
	end

	// Select the addressed ring and decide what the request does.
	always_comb begin
		in_range   = ({1'b0, core_q} < (mbr_pkg::CoreW + 1)'(CORE_COUNT));
		idx        = core_q[CW-1:0];
		wp         = wptr_q[idx];
		rp         = rptr_q[idx];
		wp_next    = (wp == PW'(RING_DEPTH - 1)) ? '0 : wp + 1'b1;
		rp_next    = (rp == PW'(RING_DEPTH - 1)) ? '0 : rp + 1'b1;
		flag       = flag_q[idx];
		do_clear   = 1'b0;
		do_flag    = 1'b0;
		do_send    = 1'b0;
		do_recv    = 1'b0;
		res_status = 1'b1;
		res_ready  = 1'b0;
		if (mode_q == mbr_pkg::MODE_CLEAR) begin
			do_clear   = 1'b1;
			res_status = 1'b0;
		end else if (in_range) begin
			unique case (mode_q)
				mbr_pkg::MODE_BIND: begin
					// Core 0 reports success without binding.
					if (idx == '0) begin
						res_status = 1'b0;
					end else if (wp == '0) begin
						do_flag    = 1'b1;
						res_status = 1'b0;
					end
				end
				mbr_pkg::MODE_READY: begin
					do_flag    = 1'b1;
					res_status = 1'b0;
				end
				mbr_pkg::MODE_QUERY: begin
					res_ready  = flag;
					res_status = 1'b0;
				end
				mbr_pkg::MODE_SEND: begin
					if (flag && (wp_next != rp)) begin
						do_send    = 1'b1;
						res_status = 1'b0;
					end
				end
				mbr_pkg::MODE_RECV: begin
					if (flag && (wp != rp)) begin
						do_recv    = 1'b1;
						res_status = 1'b0;
					end
				end
				default: begin
					res_status = 1'b1;
				end
			endcase
		end
	end

	// Flags and pointer pairs.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flag_q <= '0;
			for (int i = 0; i < CORE_COUNT; i++) begin
				wptr_q[i] <= '0;
				rptr_q[i] <= '0;
			end
		end else if (cmd.exec) begin
			if (do_clear) begin
				flag_q <= '0;
				for (int i = 0; i < CORE_COUNT; i++) begin
					wptr_q[i] <= '0;
					rptr_q[i] <= '0;
				end
			end else begin
				if (do_flag) begin
					flag_q[idx] <= 1'b1;
				end
				if (do_send) begin
					wptr_q[idx] <= wp_next;
				end
				if (do_recv) begin
					rptr_q[idx] <= rp_next;
				end
			end
		end
	end

	// Message memory: at most one write or one registered read per request.
	always_ff @(posedge clk) begin
		if (cmd.exec && do_send) begin
			mem[AW'({idx, wp})] <= msg_q;
		end
		if (cmd.exec && do_recv) begin
			rdata_q <= mem[AW'({idx, rp})];
		end
	end

	// Result word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_q  <= 1'b0;
			ready_q   <= 1'b0;
			recv_ok_q <= 1'b0;
		end else if (cmd.exec) begin
			status_q  <= res_status;
			ready_q   <= res_ready;
			recv_ok_q <= do_recv;
		end
	end

	assign status      = status_q;
	assign ready_res   = ready_q;
	assign message_out = recv_ok_q ? rdata_q : '0;

endmodule

FILE: rtl/per_core_mailbox_rings.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Per-core mailbox rings
// A bank of message rings, one per core, each with a bound flag.
// ----------------------------------------------------------------------------
// Usage:
// Requests arrive on the input channel (in_valid/in_stall) as a word of
// mode, core and message. Each request gives exactly one result word on
// the output channel (out_valid/out_stall): status, ready_res and
// message_out. A word moves at a clock edge where valid is high and stall
// is low.
// Sequence: a request is captured in S_IDLE, executed in S_EXEC (any flag or
// pointer update plus at most one access of the message memory) and its
// result is shown in S_OUT. The block handles one request at a time, so it
// takes no new word until the result of the last one has been taken. The
// capture step, the execute step with its registered memory read and the
// result step, with only one request in flight, form the path of each request.
// Stall: while out_stall holds the result, it stays unchanged and in_stall
// stays high, so no further request is taken.
// Reset: arst_n clears every bound flag and pointer pair at once; the
// block is ready for a request as soon as reset is released. Message
// memory contents are not cleared and cannot be reached until written.
// ----------------------------------------------------------------------------
module per_core_mailbox_rings #(
	parameter int CORE_COUNT = mbr_pkg::CoreCountDef,
	parameter int RING_DEPTH = mbr_pkg::RingDepthDef
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [mbr_pkg::ModeW-1:0] mode,
	input  logic [mbr_pkg::CoreW-1:0] core,
	input  logic [mbr_pkg::MsgW-1:0]  message,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic                      status,
	output logic                      ready_res,
	output logic [mbr_pkg::MsgW-1:0]  message_out
);

	mbr_pkg::cmd_t cmd;

	// Request sequencer.
	mbr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	// Ring state and message memory.
	mbr_datapath #(
		.CORE_COUNT (CORE_COUNT),
		.RING_DEPTH (RING_DEPTH)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.mode        (mode),
		.core        (core),
		.message     (message),
		.status      (status),
		.ready_res   (ready_res),
		.message_out (message_out)
	);

endmodule

FILE: tb/per_core_mailbox_rings_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Per-core mailbox rings testbench
// Sends request words of mode, core and message, predicts each result word
// from a shadow copy of the bound flags, ring pointers and ring contents,
// and compares every result word field by field. Idle gaps on the request
// side and stalls on the result side vary from phase to phase.
// ----------------------------------------------------------------------------
module per_core_mailbox_rings_test;

	localparam int CORES = mbr_pkg::CoreCountDef;
	localparam int DEPTH = mbr_pkg::RingDepthDef;

	typedef logic [mbr_pkg::ModeW-1:0] mode_t;
	typedef logic [mbr_pkg::CoreW-1:0] core_t;
	typedef logic [mbr_pkg::MsgW-1:0]  msg_t;

	// Mode codes the block does not define; both must be refused.
	localparam mode_t MODE_SPARE_6 = 3'd6;
	localparam mode_t MODE_SPARE_7 = 3'd7;

	typedef struct packed {
		logic status;
		logic ready;
		msg_t msg;
	} reply_t;

	logic            clk = 1'b0;
	logic            arst_n = 1'b0;
	logic            in_valid = 1'b0;
	logic            in_stall;
	mode_t           mode = '0;
	core_t           core = '0;
	msg_t            message = '0;
	logic            out_valid;
	logic            out_stall = 1'b0;
	logic            status;
	logic            ready_res;
	msg_t            message_out;

	// Shadow copy of the mailbox state.
	logic            bound_flag [CORES];
	int unsigned     wr_ptr [CORES];
	int unsigned     rd_ptr [CORES];
	msg_t            ring_mem [CORES*DEPTH];
	reply_t          pending_replies [$];

	// Traffic shaping and bookkeeping.
	int send_gap_pct = 0;
	int stall_pct = 0;
	int hold_left = 0;
	int error_count = 0;
	int words_sent = 0;
	int replies_seen = 0;
	int full_refusals = 0;
	int empty_refusals = 0;

	per_core_mailbox_rings i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.mode        (mode),
		.core        (core),
		.message     (message),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.ready_res   (ready_res),
		.message_out (message_out)
	);

	always #5 clk = ~clk;

	// Hard limit on the whole run.
	initial begin
		#5_000_000;
		$display("FAIL");
		$finish;
	end

	// Clear flags and pointers; ring contents stay but become unreachable.
	function automatic void clear_shadow();
		for (int i = 0; i < CORES; i++) begin
			bound_flag[i] = 1'b0;
			wr_ptr[i] = 0;
			rd_ptr[i] = 0;
		end
	endfunction

	// Work out the result word of one request and update the shadow state.
	function automatic reply_t mailbox_predict(input mode_t m, input core_t c,
			input msg_t d);
		reply_t r;
		int unsigned wp;
		int unsigned rp;
		int unsigned nxt;
		r = '{status: 1'b1, ready: 1'b0, msg: '0};
		if (m == mbr_pkg::MODE_CLEAR) begin
			clear_shadow();
			r.status = 1'b0;
		end else if (c < CORES) begin
			wp = wr_ptr[c];
			rp = rd_ptr[c];
			nxt = (wp + 1) % DEPTH;
			case (m)
				mbr_pkg::MODE_BIND: begin
					// Core 0 is accepted but never bound by this request.
					if (c == 0) begin
						r.status = 1'b0;
					end else if (wp == 0) begin
						bound_flag[c] = 1'b1;
						r.status = 1'b0;
					end
				end
				mbr_pkg::MODE_READY: begin
					bound_flag[c] = 1'b1;
					r.status = 1'b0;
				end
				mbr_pkg::MODE_QUERY: begin
					r.ready = bound_flag[c];
					r.status = 1'b0;
				end
				mbr_pkg::MODE_SEND: begin
					if (bound_flag[c] && nxt != rp) begin
						ring_mem[c*DEPTH + wp] = d;
						wr_ptr[c] = nxt;
						r.status = 1'b0;
					end else if (bound_flag[c]) begin
						full_refusals++;
					end
				end
				mbr_pkg::MODE_RECV: begin
					if (bound_flag[c] && wp != rp) begin
						r.msg = ring_mem[c*DEPTH + rp];
						rd_ptr[c] = (rp + 1) % DEPTH;
						r.status = 1'b0;
					end else if (bound_flag[c]) begin
						empty_refusals++;
					end
				end
				default: begin
				end
			endcase
		end
		return r;
	endfunction

	task automatic report_mismatch(input string field, input msg_t got, input msg_t want);
		$display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, field, got, want);
		error_count++;
	endtask

	// Offer one request word, after an optional idle gap, and hold it until taken.
	task automatic send_word(input mode_t m, input core_t c, input msg_t d);
		while ($urandom_range(0, 99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= m;
		core <= c;
		message <= d;
		do @(posedge clk); while (in_stall);
		pending_replies.push_back(mailbox_predict(m, c, d));
		words_sent++;
	endtask

	// Stop offering and wait until every predicted result word has come back.
	task automatic wait_for_replies();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_replies.size() != 0) @(posedge clk);
	endtask

	// Mostly sends and receives on in-range cores, with some noise mixed in.
	task automatic send_random_word();
		mode_t m;
		core_t c;
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 1) m = mbr_pkg::MODE_CLEAR;
		else if (pick < 5) m = mbr_pkg::MODE_BIND;
		else if (pick < 11) m = mbr_pkg::MODE_READY;
		else if (pick < 17) m = mbr_pkg::MODE_QUERY;
		else if (pick < 57) m = mbr_pkg::MODE_SEND;
		else if (pick < 95) m = mbr_pkg::MODE_RECV;
		else m = pick[0] ? MODE_SPARE_6 : MODE_SPARE_7;
		if ($urandom_range(0, 99) < 88) c = core_t'($urandom_range(0, CORES - 1));
		else c = core_t'($urandom_range(CORES, 255));
		send_word(m, c, {$urandom(), $urandom()});
	endtask

	// Result side: check every accepted result word, then pick the next stall.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_replies.size() == 0) begin
				report_mismatch("unexpected result word", msg_t'({status, ready_res}), '0);
			end else begin
				if (status !== pending_replies[0].status)
					report_mismatch("status", msg_t'(status),
						msg_t'(pending_replies[0].status));
				if (ready_res !== pending_replies[0].ready)
					report_mismatch("ready_res", msg_t'(ready_res),
						msg_t'(pending_replies[0].ready));
				if (message_out !== pending_replies[0].msg)
					report_mismatch("message_out", message_out, pending_replies[0].msg);
				void'(pending_replies.pop_front());
			end
			replies_seen++;
		end
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else begin
			out_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	// Extremes of every field, every mode and the corner cases of each.
	task automatic test_directed();
		send_gap_pct = 0;
		stall_pct = 0;
		send_word(mbr_pkg::MODE_QUERY, '0, '0);
		send_word(mbr_pkg::MODE_SEND, '0, '1);
		send_word(mbr_pkg::MODE_RECV, '0, '0);
		// Binding core 0 succeeds but leaves it unbound.
		send_word(mbr_pkg::MODE_BIND, '0, '0);
		send_word(mbr_pkg::MODE_QUERY, '0, '0);
		send_word(mbr_pkg::MODE_BIND, core_t'(CORES - 1), '0);
		send_word(mbr_pkg::MODE_QUERY, core_t'(CORES - 1), '1);
		send_word(mbr_pkg::MODE_SEND, core_t'(CORES - 1), '1);
		send_word(mbr_pkg::MODE_SEND, core_t'(CORES - 1), '0);
		// A ring that already holds words cannot be bound again.
		send_word(mbr_pkg::MODE_BIND, core_t'(CORES - 1), '0);
		send_word(mbr_pkg::MODE_RECV, core_t'(CORES - 1), '0);
		send_word(mbr_pkg::MODE_RECV, core_t'(CORES - 1), '0);
		send_word(mbr_pkg::MODE_RECV, core_t'(CORES - 1), '0);
		// Core 0 works once marked ready.
		send_word(mbr_pkg::MODE_READY, '0, '0);
		send_word(mbr_pkg::MODE_SEND, '0, 64'hA5A5_5A5A_F00F_0FF0);
		send_word(mbr_pkg::MODE_RECV, '0, '0);
		// Out-of-range cores fail in every mode but clear, spare codes fail, and clear resets the rings.
		send_word(mbr_pkg::MODE_BIND, core_t'(CORES), '0);
		send_word(mbr_pkg::MODE_READY, core_t'(CORES), '0);
		send_word(mbr_pkg::MODE_QUERY, '1, '0);
		send_word(mbr_pkg::MODE_SEND, '1, '1);
		send_word(mbr_pkg::MODE_RECV, core_t'(CORES), '0);
		send_word(MODE_SPARE_6, core_t'(1), '1);
		send_word(MODE_SPARE_7, '0, '0);
		send_word(mbr_pkg::MODE_CLEAR, '1, '1);
		send_word(mbr_pkg::MODE_QUERY, core_t'(CORES - 1), '0);
		send_word(mbr_pkg::MODE_SEND, core_t'(CORES - 1), '1);
		wait_for_replies();
	endtask

	// Fill one ring past capacity, drain it past empty, then wrap the pointers.
	task automatic test_fill_and_wrap();
		core_t c;
		c = core_t'($urandom_range(1, CORES - 1));
		send_gap_pct = 10;
		stall_pct = 10;
		send_word(mbr_pkg::MODE_READY, c, '0);
		repeat (DEPTH) send_word(mbr_pkg::MODE_SEND, c, {$urandom(), $urandom()});
		repeat (DEPTH) send_word(mbr_pkg::MODE_RECV, c, '0);
		repeat (DEPTH / 2 + 3) begin
			send_word(mbr_pkg::MODE_SEND, c, {$urandom(), $urandom()});
			send_word(mbr_pkg::MODE_RECV, c, '0);
		end
		wait_for_replies();
	endtask

	// Hold the result side off for a long stretch while requests keep coming.
	task automatic test_backpressure();
		send_gap_pct = 0;
		stall_pct = 0;
		hold_left = 80;
		send_word(mbr_pkg::MODE_READY, core_t'(2), '0);
		repeat (20) send_word($urandom_range(0, 1) ? mbr_pkg::MODE_SEND : mbr_pkg::MODE_RECV,
			core_t'(2), {$urandom(), $urandom()});
		wait_for_replies();
	endtask

	task automatic test_random(input int count, input int gap_pct, input int stall);
		send_gap_pct = gap_pct;
		stall_pct = stall;
		repeat (count) send_random_word();
		wait_for_replies();
	endtask

	initial begin
		clear_shadow();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_fill_and_wrap();
		test_backpressure();
		test_random(90, 0, 0);
		test_random(90, 58, 0);
		test_random(90, 0, 58);
		test_random(90, 18, 18);

		// Let any late or stray result word show up before judging.
		for (int n = 0; n < 2000 && pending_replies.size() != 0; n++) @(posedge clk);
		repeat (10) @(posedge clk);
		if (pending_replies.size() != 0) begin
			$display("%0d result words never arrived", pending_replies.size());
			error_count++;
		end
		$display("Covered %0d requests over all modes, spare codes and out-of-range cores;",
			words_sent);
		$display("%0d result words checked, %0d full-ring and %0d empty-ring refusals.",
			replies_seen, full_refusals, empty_refusals);
		if (error_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
